// ===== hw/rtl/rrcc_pkg.sv =====
`timescale 1ns / 1ps
package rrcc_pkg;

  localparam int TRIG_W  = 16;
  localparam int EXT_W   = 15;
  localparam int VERT_W  = 26;
  localparam int DIFF_W  = VERT_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 1'd1;

  localparam logic [EXT_W-1:0] HALF_LENGTH_RST = 15'd768;
  localparam logic [EXT_W-1:0] HALF_WIDTH_RST  = 15'd384;

  localparam longint unsigned Q30_ONE    = 64'd1 << 30;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned TRIG_ONE   = 64'd16384;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [VERT_W-1:0] vert_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // quarter-wave sine entry, Q1.14, evaluated at elaboration only
  function automatic longint unsigned qsin(input int k, input int tbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned r;
    x  = (longint'(k) * TWO_PI_Q30) >> tbits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 156;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    r  = (s + (64'd1 << 15)) >> 16;
    if (r > TRIG_ONE) begin
      r = TRIG_ONE;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rotated_rectangle_corner_collision_unit.sv =====
`timescale 1ns / 1ps
// pipeline: six register stages, a to f; the edge that accepts the request
// loads the first, and the result is valid once stage f holds it
// throughput: one request per cycle while out_stall is low; each stage holds
// its own valid bit and moves on whenever the stage after it is empty or moving
// reset: synchronous, clears all valid bits and loads half_length 768, half_width 384
module rotated_rectangle_corner_collision_unit #(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_BITS      = 16,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rrcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrcc_pkg::EXT_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              own_x,
  input  logic signed [15:0]              own_y,
  input  logic [15:0]                     own_heading,
  input  logic signed [15:0]              other_x,
  input  logic signed [15:0]              other_y,
  input  logic [15:0]                     other_heading,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            collided,
  output logic [3:0]                      corner_inside
);
  import rrcc_pkg::*;

  localparam int T   = TRIG_TABLE_BITS;
  localparam int QN  = 1 << (T - 2);
  localparam int CBW = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam logic [15:0] HEAD_KEEP = 16'hFFFF << (16 - ANGLE_BITS);

  logic [EXT_W-1:0] half_length;
  logic [EXT_W-1:0] half_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= HALF_LENGTH_RST;
      half_width  <= HALF_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_LENGTH: half_length <= cfg_data;
        REG_HALF_WIDTH:  half_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // quarter-wave sine table
  logic [14:0] qrom [QN+1];
  for (genvar g = 0; g <= QN; g++) begin : g_qrom
    assign qrom[g] = 15'(qsin(g, T));
  end

  // stage valids and advance
  logic va, vb, vc, vd, ve;
  logic ena, enb, enc, end_, ene, enf;

  assign enf      = !out_valid || !out_stall;
  assign ene      = !ve || enf;
  assign end_     = !vd || ene;
  assign enc      = !vc || end_;
  assign enb      = !vb || enc;
  assign ena      = !va || enb;
  assign in_stall = !ena;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      ve        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ena) va <= in_valid;
      if (enb) vb <= va;
      if (enc) vc <= vb;
      if (end_) vd <= vc;
      if (ene) ve <= vd;
      if (enf) out_valid <= ve;
    end
  end

  // stage a: table lookup and centres
  logic [15:0]      head [2];
  logic [15:0]      px [2];
  logic [15:0]      py [2];
  trig_t            trig_next [2][2];
  vert_t            cx_next [2];
  vert_t            cy_next [2];

  assign head[0] = own_heading;
  assign head[1] = other_heading;
  assign px[0]   = own_x;
  assign px[1]   = other_x;
  assign py[0]   = own_y;
  assign py[1]   = other_y;

  always_comb begin
    logic [15:0]  hm;
    logic [T-1:0] id;
    logic [T-1:0] base;
    logic [T-3:0] r;
    logic [T-2:0] ra;
    trig_t        v;
    for (int p = 0; p < 2; p++) begin
      hm   = head[p] & HEAD_KEEP;
      base = hm[15 -: T];
      for (int w = 0; w < 2; w++) begin
        id = (w == 0) ? base : base + T'(QN);
        r  = id[T-3:0];
        ra = id[T-2] ? (T-1)'(QN) - {1'b0, r} : {1'b0, r};
        v  = trig_t'({1'b0, qrom[ra]});
        trig_next[p][w] = id[T-1] ? -v : v;
      end
      cx_next[p] = vert_t'($signed(px[p][CBW-1:0])) <<< 6;
      cy_next[p] = vert_t'($signed(py[p][CBW-1:0])) <<< 6;
    end
  end

  trig_t sn_a [2];
  trig_t cs_a [2];
  vert_t cx_a [2];
  vert_t cy_a [2];

  always_ff @(posedge clk) begin
    if (ena) begin
      for (int p = 0; p < 2; p++) begin
        sn_a[p] <= trig_next[p][0];
        cs_a[p] <= trig_next[p][1];
        cx_a[p] <= cx_next[p];
        cy_a[p] <= cy_next[p];
      end
    end
  end

  // stage b: rotation products
  logic signed [31:0] cl_b [2];
  logic signed [31:0] sw_b [2];
  logic signed [31:0] sl_b [2];
  logic signed [31:0] cw_b [2];
  vert_t              cx_b [2];
  vert_t              cy_b [2];
  logic signed [15:0] len_s;
  logic signed [15:0] wid_s;

  assign len_s = {1'b0, half_length};
  assign wid_s = {1'b0, half_width};

  always_ff @(posedge clk) begin
    if (enb) begin
      for (int p = 0; p < 2; p++) begin
        cl_b[p] <= cs_a[p] * len_s;
        sw_b[p] <= sn_a[p] * wid_s;
        sl_b[p] <= sn_a[p] * len_s;
        cw_b[p] <= cs_a[p] * wid_s;
        cx_b[p] <= cx_a[p];
        cy_b[p] <= cy_a[p];
      end
    end
  end

  // stage c: corners, offsets rounded half up to 2^-6
  function automatic vert_t rnd(input logic signed [32:0] v);
    logic signed [32:0] b;
    b = v + 33'sd128;
    return vert_t'($signed(b[32:8]));
  endfunction

  vert_t vx_next [2][4];
  vert_t vy_next [2][4];

  always_comb begin
    logic signed [32:0] cl, sw, sl, cw;
    for (int p = 0; p < 2; p++) begin
      cl = 33'(cl_b[p]);
      sw = 33'(sw_b[p]);
      sl = 33'(sl_b[p]);
      cw = 33'(cw_b[p]);
      vx_next[p][0] = cx_b[p] + rnd(cl - sw);
      vy_next[p][0] = cy_b[p] + rnd(sl + cw);
      vx_next[p][1] = cx_b[p] + rnd(-cl - sw);
      vy_next[p][1] = cy_b[p] + rnd(-sl + cw);
      vx_next[p][2] = cx_b[p] + rnd(-cl + sw);
      vy_next[p][2] = cy_b[p] + rnd(-sl - cw);
      vx_next[p][3] = cx_b[p] + rnd(cl + sw);
      vy_next[p][3] = cy_b[p] + rnd(sl - cw);
    end
  end

  vert_t vx_c [2][4];
  vert_t vy_c [2][4];

  always_ff @(posedge clk) begin
    if (enc) begin
      vx_c <= vx_next;
      vy_c <= vy_next;
    end
  end

  // stage d: edge differences per obstacle corner and vehicle edge
  diff_t d_d  [4][4];
  diff_t a1_d [4][4];
  diff_t b1_d [4][4];
  diff_t b2_d [4][4];
  logic  cr_d [4][4];

  always_ff @(posedge clk) begin
    if (end_) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 4; i++) begin
          cr_d[k][i] <= (vy_c[0][i] > vy_c[1][k]) != (vy_c[0][(i+3)%4] > vy_c[1][k]);
          d_d[k][i]  <= diff_t'(vy_c[0][(i+3)%4]) - diff_t'(vy_c[0][i]);
          a1_d[k][i] <= diff_t'(vx_c[1][k]) - diff_t'(vx_c[0][i]);
          b1_d[k][i] <= diff_t'(vx_c[0][(i+3)%4]) - diff_t'(vx_c[0][i]);
          b2_d[k][i] <= diff_t'(vy_c[1][k]) - diff_t'(vy_c[0][i]);
        end
      end
    end
  end

  // stage e: cross products
  prod_t lhs_e [4][4];
  prod_t rhs_e [4][4];
  logic  dp_e  [4][4];
  logic  cr_e  [4][4];

  always_ff @(posedge clk) begin
    if (ene) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 4; i++) begin
          lhs_e[k][i] <= a1_d[k][i] * d_d[k][i];
          rhs_e[k][i] <= b1_d[k][i] * b2_d[k][i];
          dp_e[k][i]  <= d_d[k][i] > 0;
          cr_e[k][i]  <= cr_d[k][i];
        end
      end
    end
  end

  // stage f: crossing parity
  logic [3:0] mask_next;

  always_comb begin
    logic in;
    for (int k = 0; k < 4; k++) begin
      in = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (cr_e[k][i] && (dp_e[k][i] ? (lhs_e[k][i] < rhs_e[k][i])
                                      : (lhs_e[k][i] > rhs_e[k][i]))) begin
          in = !in;
        end
      end
      mask_next[k] = in;
    end
  end

  always_ff @(posedge clk) begin
    if (enf) begin
      corner_inside <= mask_next;
      collided      <= |mask_next;
    end
  end

endmodule

// ===== tb/rotated_rectangle_corner_collision_unit_tb.sv =====
`timescale 1ns / 1ps
module rotated_rectangle_corner_collision_unit_tb;
  import rrcc_pkg::*;

  typedef struct packed {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic [15:0]        oh;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic [15:0]        bh;
  } pose_pair_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] mask;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HALF_LENGTH;
  logic [EXT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] own_x = '0, own_y = '0, other_x = '0, other_y = '0;
  logic [15:0] own_heading = '0, other_heading = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic collided;
  logic [3:0] corner_inside;

  rotated_rectangle_corner_collision_unit i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .own_x(own_x), .own_y(own_y), .own_heading(own_heading),
    .other_x(other_x), .other_y(other_y), .other_heading(other_heading),
    .out_valid(out_valid), .out_stall(out_stall), .collided(collided),
    .corner_inside(corner_inside)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pose_pair_t pending_q[$];
  verdict_t verdict_q[$];
  longint signed sin_rom[1024];
  logic [EXT_W-1:0] len_reg = HALF_LENGTH_RST;
  logic [EXT_W-1:0] wid_reg = HALF_WIDTH_RST;
  int errors = 0;
  bit quiet_rx = 1'b0;
  bit calm = 1'b0;
  int hold_off = 0;

  function automatic longint signed quarter_wave(longint unsigned k);
    longint unsigned divs[6] = '{156, 110, 72, 42, 20, 6};
    longint unsigned x, x2, t, s, r;
    x = (k * 64'd6746518852) >> 10;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    for (int i = 0; i < 6; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[i];
    s = (x * t) >> 30;
    r = (s + 64'd32768) >> 16;
    if (r > 16384) r = 16384;
    return longint'(r);
  endfunction

  function automatic longint signed round_to_q14(longint signed v);
    longint unsigned b;
    b = longint'(v + (64'sd1 <<< 40)) + 128;
    return longint'(b >> 8) - (64'sd1 <<< 32);
  endfunction

  task automatic corners(input logic signed [15:0] px, py, input logic [15:0] hd,
                         output longint signed vx[4], output longint signed vy[4]);
    int sx[4] = '{1, -1, -1, 1};
    int sy[4] = '{1, 1, -1, -1};
    longint signed s, c, lx, ly;
    s = sin_rom[hd[15:6]];
    c = sin_rom[(hd[15:6] + 10'd256) & 10'h3ff];
    for (int k = 0; k < 4; k++) begin
      lx = longint'(len_reg) * sx[k];
      ly = longint'(wid_reg) * sy[k];
      vx[k] = longint'(px) * 64 + round_to_q14(c * lx - s * ly);
      vy[k] = longint'(py) * 64 + round_to_q14(s * lx + c * ly);
    end
  endtask

  function automatic bit encloses(longint signed vx[4], longint signed vy[4],
                                  longint signed tx, longint signed ty);
    bit in;
    int j;
    longint signed d, lhs, rhs;
    in = 0;
    j = 3;
    for (int i = 0; i < 4; i++) begin
      if ((vy[i] > ty) != (vy[j] > ty)) begin
        d = vy[j] - vy[i];
        lhs = (tx - vx[i]) * d;
        rhs = (vx[j] - vx[i]) * (ty - vy[i]);
        if (d > 0 ? (lhs < rhs) : (lhs > rhs)) in = !in;
      end
      j = i;
    end
    return in;
  endfunction

  task automatic predict_overlap(input pose_pair_t p);
    longint signed ax[4], ay[4], bx[4], by[4];
    verdict_t v;
    corners(p.ox, p.oy, p.oh, ax, ay);
    corners(p.bx, p.by, p.bh, bx, by);
    v.mask = '0;
    for (int k = 0; k < 4; k++) v.mask[k] = encloses(ax, ay, bx[k], by[k]);
    v.hit = |v.mask;
    verdict_q.push_back(v);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_overlap(pending_q.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
          in_valid <= 1'b1;
          {own_x, own_y, own_heading, other_x, other_y, other_heading} <= pending_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected result collided=%b mask=%b", $time, collided,
                   corner_inside);
          errors++;
        end else begin
          e = verdict_q.pop_front();
          if (collided !== e.hit) begin
            $display("%0t collided expected %b actual %b", $time, e.hit, collided);
            errors++;
          end
          if (corner_inside !== e.mask) begin
            $display("%0t corner_inside expected %b actual %b", $time, e.mask,
                     corner_inside);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_rx && !calm && ($urandom_range(99) < 7);
      end
    end
  end

  function automatic pose_pair_t random_pair(bit near);
    pose_pair_t p;
    p.oh = 16'($urandom);
    p.bh = 16'($urandom);
    if (near) begin
      p.ox = 16'($urandom);
      p.oy = 16'($urandom);
      p.bx = p.ox + $signed(16'($urandom_range(3072))) - 16'sd1536;
      p.by = p.oy + $signed(16'($urandom_range(3072))) - 16'sd1536;
    end else begin
      p.ox = 16'($urandom);
      p.oy = 16'($urandom);
      p.bx = 16'($urandom);
      p.by = 16'($urandom);
    end
    return p;
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || verdict_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [EXT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HALF_LENGTH) len_reg = val;
    else wid_reg = val;
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) pending_q.push_back(random_pair($urandom_range(99) < 75));
  endtask

  initial begin
    pose_pair_t p;
    logic [EXT_W-1:0] lens[6] = '{15'd768, 15'd0, 15'd32767, 15'd256, 15'd1200, 15'd40};
    logic [EXT_W-1:0] wids[6] = '{15'd384, 15'd300, 15'd0, 15'd32767, 15'd128, 15'd40};
    for (int k = 0; k < 1024; k++) begin
      if (k[8]) sin_rom[k] = quarter_wave(256 - k[7:0]);
      else sin_rom[k] = quarter_wave(k[7:0]);
      if (k[9]) sin_rom[k] = -sin_rom[k];
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: reset extents
    p = '{16'sd0, 16'sd0, 16'd0, 16'sd0, 16'sd0, 16'd0};
    pending_q.push_back(p);
    p = '{16'sd0, 16'sd0, 16'd0, 16'sd700, 16'sd0, 16'd16384};
    pending_q.push_back(p);
    p = '{-16'sd32768, -16'sd32768, 16'hffff, 16'sd32767, 16'sd32767, 16'hffff};
    pending_q.push_back(p);
    p = '{16'sd32767, 16'sd32767, 16'd32768, 16'sd32767, 16'sd32767, 16'd49152};
    pending_q.push_back(p);
    p = '{-16'sd32768, 16'sd32767, 16'd8192, -16'sd32768, 16'sd32767, 16'd24576};
    pending_q.push_back(p);
    p = '{16'sd0, 16'sd0, 16'd0, 16'sd1536, 16'sd768, 16'd0};
    pending_q.push_back(p);
    p = '{16'sd0, 16'sd0, 16'd0, 16'sd256, 16'sd0, 16'd63};
    pending_q.push_back(p);
    p = '{16'sh5555, -16'sh5556, 16'haaaa, -16'sh5556, 16'sh5555, 16'h5555};
    pending_q.push_back(p);
    random_phase(12);
    drain();
    // back-pressure: receiver holds off while sender keeps going
    calm = 1'b1;
    quiet_rx = 1'b1;
    hold_off = 60;
    random_phase(40);
    drain();
    random_phase(150);
    drain();
    calm = 1'b0;
    quiet_rx = 1'b0;
    for (int s = 0; s < 6; s++) begin
      write_reg(REG_HALF_LENGTH, lens[s]);
      write_reg(REG_HALF_WIDTH, wids[s]);
      random_phase(180);
      drain();
    end
    write_reg(REG_HALF_LENGTH, 15'($urandom));
    write_reg(REG_HALF_WIDTH, 15'($urandom));
    random_phase(260);
    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/rrcc_pkg.sv
hw/rtl/rotated_rectangle_corner_collision_unit.sv
tb/rotated_rectangle_corner_collision_unit_tb.sv
